### rtl/jacf_pkg.sv
// Package for the joystick axis calibration and smoothing block.
// Holds word types, field widths, reset values and the divider interface types.
// Used by every module and the checker of this block.
`default_nettype none

package jacf_pkg;

  localparam int unsigned NumAxes     = 4;
  localparam int unsigned AdcBits     = 12;
  localparam int unsigned BoundBits   = 14;
  localparam int unsigned PosBits     = 16;
  localparam int unsigned DzBits      = 15;
  localparam int unsigned AlphaBits   = 17;

  localparam int unsigned DivQuoBits  = 16;
  localparam int unsigned DivDenBits  = 16;
  localparam int unsigned DivNumBits  = DivQuoBits + DivDenBits - 1;

  localparam logic [AdcBits-1:0]          ResetCenter = AdcBits'(2048);
  localparam logic signed [BoundBits-1:0] ResetLow    = BoundBits'(1600);
  localparam logic signed [BoundBits-1:0] ResetHigh   = BoundBits'(2500);

  localparam logic [DzBits-1:0]    ResetDeadzone = DzBits'(1966);
  localparam logic [AlphaBits-1:0] ResetAlpha    = AlphaBits'(19661);
  localparam logic [AdcBits-1:0]   ResetMinSpan  = AdcBits'(200);
  localparam logic [AdcBits-1:0]   ResetMargin   = AdcBits'(300);

  localparam logic [AlphaBits-1:0] AlphaOne = AlphaBits'(65536);
  localparam logic [DivDenBits:0]  OneQ15   = (DivDenBits + 1)'(32768);
  localparam logic [DivQuoBits-1:0] MaxQ15  = DivQuoBits'(32767);

  typedef enum logic [1:0] {
    REG_DEADZONE = 2'd0,
    REG_ALPHA    = 2'd1,
    REG_MIN_SPAN = 2'd2,
    REG_MARGIN   = 2'd3
  } reg_idx_e;

  typedef enum logic {
    FUNC_SAMPLE   = 1'b0,
    FUNC_RECENTER = 1'b1
  } func_e;

  typedef struct packed {
    logic               func;
    logic [1:0]         axis_sel;
    logic [AdcBits-1:0] raw;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                axis_out;
    logic signed [PosBits-1:0] position;
  } out_word_t;

  typedef struct packed {
    logic                  start;
    logic [DivNumBits-1:0] dividend;
    logic [DivDenBits-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DivQuoBits-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/jacf_div.sv
// Restoring divider that yields one quotient bit per cycle.
// The dividend's upper part must be below the divisor. Depends on jacf_pkg.
`default_nettype none

module jacf_div
  import jacf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int unsigned CntBits = $clog2(DivQuoBits + 1);

  logic [DivDenBits-1:0] rem_q, rem_d;
  logic [DivQuoBits-1:0] low_q, low_d;
  logic [DivDenBits-1:0] den_q, den_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DivDenBits:0]   trial;
  logic                  fits;

  assign trial = {rem_q, low_q[DivQuoBits-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = DivDenBits'(req_i.dividend[DivNumBits-1:DivQuoBits]);
      low_d  = req_i.dividend[DivQuoBits-1:0];
      den_d  = req_i.divisor;
      cnt_d  = CntBits'(DivQuoBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DivDenBits'(trial - {1'b0, den_q}) : trial[DivDenBits-1:0];
      low_d = {low_q[DivQuoBits-2:0], fits};
      cnt_d = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = low_q;

endmodule

`default_nettype wire

### rtl/joystick_axis_calibrate_filter_top.sv
// Top level of the joystick axis calibration, dead zone and smoothing block.
// Depends on jacf_pkg and the shared divider jacf_div.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid_i/in_stall_o  in_data_i (in_word_t)
//   out       output     out_valid_o/out_stall_i out_data_o (out_word_t)
//   config    input      APB psel/penable/pready paddr, pwdata, prdata
//
// A sample word runs two passes of the shared divider, the second skipped below the
// dead zone; a recenter word or a word for a missing axis skips the divider. One word
// is in progress at a time: in_stall_o stays high until the block returns to idle.
// Reset restores all axis state and registers at once; no clearing pass is needed.
// A result held by out_stall_i lets the next word in, but that word waits in ST_DONE
// until the output register is free.
`default_nettype none

module joystick_axis_calibrate_filter_top
  import jacf_pkg::*;
#(
  parameter int unsigned AXES = NumAxes
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_data_o,
  input  wire logic      psel,
  input  wire logic      penable,
  input  wire logic      pwrite,
  input  wire logic [3:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int unsigned AxW = (AXES > 1) ? $clog2(AXES) : 1;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_UPD  = 8'b0000_0010,
    ST_DIV1 = 8'b0000_0100,
    ST_DZ   = 8'b0000_1000,
    ST_DIV2 = 8'b0001_0000,
    ST_MUL  = 8'b0010_0000,
    ST_ACC  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [DzBits-1:0]    dz_q;
  logic [AlphaBits-1:0] alpha_q;
  logic [AdcBits-1:0]   min_span_q;
  logic [AdcBits-1:0]   margin_q;

  logic [AdcBits-1:0]          center_q [AXES];
  logic signed [BoundBits-1:0] low_q    [AXES];
  logic signed [BoundBits-1:0] high_q   [AXES];
  logic signed [PosBits-1:0]   filt_q   [AXES];

  logic [AxW-1:0]            ax_q;
  logic [1:0]                axis_sel_q;
  logic                      ax_ok_q;
  logic                      func_q;
  logic [AdcBits-1:0]        raw_q;
  logic                      dneg_q;
  logic [DivQuoBits-1:0]     a_q;
  logic signed [PosBits-1:0] y_q;
  logic signed [34:0]        prod_q;
  logic signed [PosBits-1:0] pos_q;

  logic      out_valid_q, out_valid_d;
  out_word_t out_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                        in_accept;
  logic                        cfg_write;
  logic [AdcBits-1:0]          cur_center;
  logic signed [BoundBits-1:0] cur_low, cur_high;
  logic signed [PosBits-1:0]   cur_filt;
  logic signed [BoundBits-1:0] raw_s;
  logic signed [BoundBits-1:0] new_low, new_high;
  logic signed [BoundBits-1:0] rc_low, rc_high;
  logic signed [BoundBits:0]   span_hi, span_lo, span_max, span_floor;
  logic [AdcBits-1:0]          min_span_eff;
  logic [AdcBits-1:0]          abs_d;
  logic [DivQuoBits-1:0]       a_minus_dz;
  logic                        below_dz;
  logic [DivQuoBits-1:0]       y_clamped;
  logic signed [PosBits-1:0]   y_signed;
  logic [AlphaBits-1:0]        alpha_eff;
  logic signed [PosBits:0]     diff;
  logic signed [34:0]          prod_d;
  logic signed [35:0]          acc_num;
  logic signed [19:0]          acc_shift;
  logic signed [PosBits-1:0]   filt_new;
  logic                        out_free;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign cfg_write  = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign cur_center = center_q[ax_q];
  assign cur_low    = low_q[ax_q];
  assign cur_high   = high_q[ax_q];
  assign cur_filt   = filt_q[ax_q];

  assign raw_s    = $signed({2'b00, raw_q});
  assign new_low  = (raw_s < cur_low) ? raw_s : cur_low;
  assign new_high = (raw_s > cur_high) ? raw_s : cur_high;
  assign rc_low   = raw_s - $signed({2'b00, margin_q});
  assign rc_high  = raw_s + $signed({2'b00, margin_q});

  assign span_hi      = {new_high[BoundBits-1], new_high} - $signed({3'b000, cur_center});
  assign span_lo      = $signed({3'b000, cur_center}) - {new_low[BoundBits-1], new_low};
  assign span_max     = (span_lo > span_hi) ? span_lo : span_hi;
  assign min_span_eff = (min_span_q == '0) ? AdcBits'(1) : min_span_q;
  assign span_floor   = (span_max < $signed({3'b000, min_span_eff})) ?
                        $signed({3'b000, min_span_eff}) : span_max;

  assign abs_d = (raw_q >= cur_center) ? (raw_q - cur_center) : (cur_center - raw_q);

  assign below_dz   = a_q < {1'b0, dz_q};
  assign a_minus_dz = a_q - {1'b0, dz_q};

  assign y_clamped = (div_rsp.quotient > MaxQ15) ? MaxQ15 : div_rsp.quotient;
  assign y_signed  = dneg_q ? -$signed(y_clamped) : $signed(y_clamped);

  assign alpha_eff = (alpha_q > AlphaOne) ? AlphaOne : alpha_q;
  assign diff      = {y_q[PosBits-1], y_q} - {cur_filt[PosBits-1], cur_filt};
  assign prod_d    = $signed({1'b0, alpha_eff}) * diff;

  assign acc_num   = {{4{cur_filt[PosBits-1]}}, cur_filt, 16'h0000}
                   + {prod_q[34], prod_q};
  assign acc_shift = acc_num[35:16] + 20'((acc_num[35] && (acc_num[15:0] != '0)) ? 1 : 0);
  assign filt_new  = acc_shift[PosBits-1:0];

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DivNumBits'({abs_d, 15'h0000});
    div_req.divisor  = DivDenBits'(span_floor[BoundBits-1:0]);
    if ((state_q == ST_UPD) && ax_ok_q && (func_q == FUNC_SAMPLE)) begin
      div_req.start = 1'b1;
    end else if (state_q == ST_DZ) begin
      div_req.start    = !below_dz;
      div_req.dividend = DivNumBits'({a_minus_dz, 15'h0000}) - DivNumBits'(a_minus_dz);
      div_req.divisor  = DivDenBits'(OneQ15 - {2'b00, dz_q});
    end
  end

  jacf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (!ax_ok_q || (func_q == FUNC_RECENTER)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_rsp.done) begin
          state_d = ST_DZ;
        end
      end
      ST_DZ: begin
        state_d = below_dz ? ST_MUL : ST_DIV2;
      end
      ST_DIV2: begin
        if (div_rsp.done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q       <= ResetDeadzone;
      alpha_q    <= ResetAlpha;
      min_span_q <= ResetMinSpan;
      margin_q   <= ResetMargin;
    end else if (cfg_write) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_DEADZONE: dz_q       <= pwdata[DzBits-1:0];
        REG_ALPHA:    alpha_q    <= pwdata[AlphaBits-1:0];
        REG_MIN_SPAN: min_span_q <= pwdata[AdcBits-1:0];
        REG_MARGIN:   margin_q   <= pwdata[AdcBits-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_DEADZONE: prdata = 32'(dz_q);
      REG_ALPHA:    prdata = 32'(alpha_q);
      REG_MIN_SPAN: prdata = 32'(min_span_q);
      REG_MARGIN:   prdata = 32'(margin_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AXES; i++) begin
        center_q[i] <= ResetCenter;
        low_q[i]    <= ResetLow;
        high_q[i]   <= ResetHigh;
        filt_q[i]   <= '0;
      end
    end else begin
      if ((state_q == ST_UPD) && ax_ok_q) begin
        if (func_q == FUNC_RECENTER) begin
          center_q[ax_q] <= raw_q;
          low_q[ax_q]    <= rc_low;
          high_q[ax_q]   <= rc_high;
          filt_q[ax_q]   <= '0;
        end else begin
          low_q[ax_q]  <= new_low;
          high_q[ax_q] <= new_high;
        end
      end
      if (state_q == ST_ACC) begin
        filt_q[ax_q] <= filt_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ax_q       <= AxW'(in_data_i.axis_sel);
      axis_sel_q <= in_data_i.axis_sel;
      ax_ok_q    <= 32'(in_data_i.axis_sel) < 32'(AXES);
      func_q     <= in_data_i.func;
      raw_q      <= in_data_i.raw;
    end
    if (state_q == ST_UPD) begin
      dneg_q <= raw_q < cur_center;
      pos_q  <= '0;
    end
    if ((state_q == ST_DIV1) && div_rsp.done) begin
      a_q <= div_rsp.quotient;
    end
    if ((state_q == ST_DZ) && below_dz) begin
      y_q <= '0;
    end
    if ((state_q == ST_DIV2) && div_rsp.done) begin
      y_q <= y_signed;
    end
    if (state_q == ST_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_ACC) begin
      pos_q <= filt_new;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_q.axis_out <= axis_sel_q;
      out_q.position <= pos_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/jacf_checker.sv
// Port-level checker for the joystick axis calibration block, bound to its top level.
// Depends on jacf_pkg for the word types.
`default_nettype none

module jacf_checker
  import jacf_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_word_t out_data_o
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Output word dropped while stalled.");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("Output word changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input taken again before the word was processed.");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("Result appeared without a word in progress.");

  a_position_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.position != 16'sh8000))
    else $error("Position outside its range.");

endmodule

bind joystick_axis_calibrate_filter_top jacf_checker u_jacf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

### bench/joystick_axis_calibrate_filter_top_tb.sv
// Self-checking testbench for joystick_axis_calibrate_filter_top.
// A predictor of the axis calibration and smoothing filter checks every output word;
// directed rows may pin the expected position. Depends on jacf_pkg and the block's RTL only.
`timescale 1ns / 1ps

module joystick_axis_calibrate_filter_top_tb;
  import jacf_pkg::*;

  localparam longint QOne     = 32768;
  localparam longint QMax     = 32767;
  localparam longint AlphaMax = 65536;
  localparam int     AdcMax   = (1 << AdcBits) - 1;
  localparam int     CycleLimit = 2_000_000;
  localparam int     NumPhases  = 8;
  localparam int     WordsPerPhase = 235;
  localparam int     SettleCycles  = 60;
  localparam int     HoldCycles    = 800;

  typedef struct {
    func_e    func;
    bit [1:0] axis;
    int       raw;
    bit       pinned;
    int       pos;
  } dir_row_t;

  typedef struct {
    int dz;
    int alpha;
    int mspan;
    int margin;
  } setting_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  in_word_t        in_data = '0;
  logic            in_stall;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_word_t       out_data;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [3:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;

  bit              pin_flag = 1'b0;
  int              pin_value = 0;
  bit              hold_req = 1'b0;

  int              cfg_deadzone, cfg_alpha, cfg_min_span, cfg_margin;
  int              cal_center [NumAxes];
  int              cal_low    [NumAxes];
  int              cal_high   [NumAxes];
  int              cal_filt   [NumAxes];

  out_word_t       pending_words [$];
  int              fail_count = 0;
  int              cycle_count = 0;
  int              words_in = 0;
  int              words_out = 0;
  int              recenters = 0;
  int              settings_run = 0;

  dir_row_t dir_rows [0:20] = '{
    '{FUNC_SAMPLE,   2'd0, 2048, 1'b1, 0},
    '{FUNC_SAMPLE,   2'd1, 4095, 1'b0, 0},
    '{FUNC_SAMPLE,   2'd1, 4095, 1'b0, 0},
    '{FUNC_SAMPLE,   2'd2,    0, 1'b0, 0},
    '{FUNC_SAMPLE,   2'd2,    0, 1'b0, 0},
    '{FUNC_RECENTER, 2'd3,    0, 1'b1, 0},
    '{FUNC_SAMPLE,   2'd3,    0, 1'b1, 0},
    '{FUNC_SAMPLE,   2'd3, 4095, 1'b0, 0},
    '{FUNC_RECENTER, 2'd2, 4095, 1'b1, 0},
    '{FUNC_SAMPLE,   2'd2, 4095, 1'b1, 0},
    '{FUNC_SAMPLE,   2'd2,    0, 1'b0, 0},
    '{FUNC_RECENTER, 2'd1, 2048, 1'b1, 0},
    '{FUNC_SAMPLE,   2'd1, 2100, 1'b0, 0},
    '{FUNC_SAMPLE,   2'd1, 2060, 1'b0, 0},
    '{FUNC_SAMPLE,   2'd0, 2730, 1'b0, 0},
    '{FUNC_SAMPLE,   2'd0, 1365, 1'b0, 0},
    '{FUNC_RECENTER, 2'd0, 2730, 1'b1, 0},
    '{FUNC_SAMPLE,   2'd0, 1365, 1'b0, 0},
    '{FUNC_SAMPLE,   2'd3, 2048, 1'b0, 0},
    '{FUNC_RECENTER, 2'd1, 4095, 1'b1, 0},
    '{FUNC_SAMPLE,   2'd1,    0, 1'b0, 0}
  };

  setting_t fixed_settings [0:3] = '{
    '{1966, 19661, 200, 300},
    '{0, 65536, 1, 0},
    '{32767, 0, 4095, 4095},
    '{100, 131071, 0, 50}
  };

  joystick_axis_calibrate_filter_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic out_word_t calibrate_word(in_word_t w);
    int        ax, raw, c, span, floor_span, d;
    longint    a, dz, y, al, num;
    out_word_t r;
    ax = int'(w.axis_sel);
    raw = int'(w.raw);
    r.axis_out = w.axis_sel;
    r.position = '0;
    if (w.func == FUNC_RECENTER) begin
      cal_center[ax] = raw;
      cal_low[ax] = raw - cfg_margin;
      cal_high[ax] = raw + cfg_margin;
      cal_filt[ax] = 0;
    end else begin
      c = cal_center[ax];
      if (raw < cal_low[ax]) cal_low[ax] = raw;
      if (raw > cal_high[ax]) cal_high[ax] = raw;
      span = cal_high[ax] - c;
      if (c - cal_low[ax] > span) span = c - cal_low[ax];
      floor_span = (cfg_min_span == 0) ? 1 : cfg_min_span;
      if (span < floor_span) span = floor_span;
      d = raw - c;
      a = (longint'(d < 0 ? -d : d) * QOne) / span;
      dz = cfg_deadzone;
      if (a < dz) begin
        y = 0;
      end else begin
        y = ((a - dz) * QMax) / (QOne - dz);
        if (y > QMax) y = QMax;
        if (d < 0) y = -y;
      end
      al = (cfg_alpha > AlphaMax) ? AlphaMax : cfg_alpha;
      num = (AlphaMax - al) * longint'(cal_filt[ax]) + al * y;
      cal_filt[ax] = int'(num / AlphaMax);
      r.position = 16'(cal_filt[ax]);
    end
    return r;
  endfunction

  task automatic note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : scoreboard
    out_word_t predicted;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predicted = calibrate_word(in_data);
        if (pin_flag) predicted.position = 16'(pin_value);
        pending_words.push_back(predicted);
        words_in++;
        if (in_data.func == FUNC_RECENTER) recenters++;
      end
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          note_fail($sformatf("unexpected word: axis %0d position %0d",
                              out_data.axis_out, out_data.position));
        end else begin
          predicted = pending_words.pop_front();
          if (out_data.axis_out !== predicted.axis_out)
            note_fail($sformatf("word %0d axis: expected %0d, got %0d",
                                words_out, predicted.axis_out, out_data.axis_out));
          if (out_data.position !== predicted.position)
            note_fail($sformatf("word %0d axis %0d position: expected %0d, got %0d",
                                words_out, predicted.axis_out, predicted.position,
                                out_data.position));
        end
        words_out++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, pending_words.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : receiver
    int mode, len;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HoldCycles) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      mode = $urandom_range(0, 9);
      len = $urandom_range(20, 200);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          0, 1, 2, 3: out_stall <= 1'b0;
          4, 5, 6, 7: out_stall <= ($urandom_range(0, 1) == 1);
          8:          out_stall <= ($urandom_range(0, 4) != 0);
          default:    out_stall <= 1'b1;
        endcase
      end
    end
  end

  task automatic offer_word(in_word_t w, bit pinned, int pos);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    pin_flag <= pinned;
    pin_value <= pos;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic go_idle(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    pin_flag <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic apb_xfer(bit wr, reg_idx_e idx, logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_register(reg_idx_e idx, int value);
    logic [31:0] rd, stored;
    case (idx)
      REG_DEADZONE: begin
        stored = value & ((1 << DzBits) - 1);
        cfg_deadzone = stored;
      end
      REG_ALPHA: begin
        stored = value & ((1 << AlphaBits) - 1);
        cfg_alpha = stored;
      end
      REG_MIN_SPAN: begin
        stored = value & AdcMax;
        cfg_min_span = stored;
      end
      default: begin
        stored = value & AdcMax;
        cfg_margin = stored;
      end
    endcase
    apb_xfer(1'b1, idx, value, rd);
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== stored)
      note_fail($sformatf("register %s reads %0d, written %0d", idx.name(), rd, stored));
  endtask

  task automatic drain();
    go_idle(0);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick, v;
    w.func = ($urandom_range(0, 99) < 8) ? FUNC_RECENTER : FUNC_SAMPLE;
    w.axis_sel = 2'($urandom_range(0, NumAxes - 1));
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      v = $urandom_range(0, AdcMax);
    end else if (pick < 8) begin
      v = cal_center[w.axis_sel] + $urandom_range(0, 600) * ($urandom_range(0, 1) ? 1 : -1);
      if (v < 0) v = 0;
      if (v > AdcMax) v = AdcMax;
    end else begin
      v = $urandom_range(0, 1) ? AdcMax : 0;
    end
    w.raw = AdcBits'(v);
    return w;
  endfunction

  initial begin : stimulus
    in_word_t w;
    setting_t s;
    int       burst;
    for (int i = 0; i < NumAxes; i++) begin
      cal_center[i] = int'(ResetCenter);
      cal_low[i] = int'(ResetLow);
      cal_high[i] = int'(ResetHigh);
      cal_filt[i] = 0;
    end
    cfg_deadzone = int'(ResetDeadzone);
    cfg_alpha = int'(ResetAlpha);
    cfg_min_span = int'(ResetMinSpan);
    cfg_margin = int'(ResetMargin);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      w.func = dir_rows[i].func;
      w.axis_sel = dir_rows[i].axis;
      w.raw = AdcBits'(dir_rows[i].raw);
      offer_word(w, dir_rows[i].pinned, dir_rows[i].pos);
    end
    settings_run++;

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      if (p < 4) begin
        s = fixed_settings[p];
      end else begin
        s.dz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 6000);
        s.alpha = $urandom_range(0, 131071);
        s.mspan = $urandom_range(0, AdcMax);
        s.margin = $urandom_range(0, AdcMax);
      end
      set_register(REG_DEADZONE, s.dz);
      set_register(REG_ALPHA, s.alpha);
      set_register(REG_MIN_SPAN, s.mspan);
      set_register(REG_MARGIN, s.margin);
      settings_run++;
      if (p == 0) hold_req = 1'b1;
      burst = $urandom_range(1, 12);
      for (int n = 0; n < WordsPerPhase; n++) begin
        if (burst == 0) begin
          go_idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50));
          burst = $urandom_range(1, 12);
        end
        offer_word(random_word(), 1'b0, 0);
        burst--;
      end
    end

    drain();
    if (pending_words.size() != 0) fail_count += pending_words.size();
    $display("Checked %0d output words (%0d recenters) from %0d input words",
             words_out, recenters, words_in);
    $display("over %0d register settings, with random idling and one long output hold-off.",
             settings_run);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches found", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/jacf_pkg.sv
rtl/jacf_div.sv
rtl/joystick_axis_calibrate_filter_top.sv
rtl/jacf_checker.sv
bench/joystick_axis_calibrate_filter_top_tb.sv
